### design/gntb_pkg.sv
`default_nettype none

package gntb_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_CITY_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOUR_MODE  = 1'b1;

    // Register widths and reset values
    localparam int CITY_COUNT_W     = 6;
    localparam int CITY_COUNT_RESET = 32;

    // Tour modes
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_FARTHEST = 1'b1;

    // Stream payload widths
    localparam int DIST_IN_W   = 24;
    localparam int CITY_OUT_W  = 5;
    localparam int LEN_W       = 30;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Parameter defaults for the top level
    localparam int MAX_CITIES_DEFAULT     = 32;
    localparam int DISTANCE_WIDTH_DEFAULT = 24;

endpackage

`default_nettype wire

### design/greedy_neighbor_tour_builder.sv
`default_nettype none

// Greedy neighbor tour builder. The distance matrix of city_count cities is
// streamed in row by row (row = source city), one entry per transfer, and is
// taken at one entry per cycle. The transfer that completes the matrix starts
// a tour from city 0 that moves to the nearest (tour_mode 0) or farthest
// (tour_mode 1) unvisited city, lowest index on ties, and closes at city 0.
// The tour gives city_count+1 result transfers: the city and the running
// length, with tlast on the return to city 0. A single compare unit scans one
// matrix row per step, one candidate per cycle from the distance memory; no
// input is taken until the last result sits in the output register. Writing
// city_count restarts the matrix load.
module greedy_neighbor_tour_builder #(
    parameter int MAX_CITIES     = gntb_pkg::MAX_CITIES_DEFAULT,
    parameter int DISTANCE_WIDTH = gntb_pkg::DISTANCE_WIDTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [gntb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gntb_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: [23:0] distance
    input  wire logic [gntb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: [4:0] city, [34:5] running_length, [39:35] zero
    output logic [gntb_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                     m_axis_tlast
);
    import gntb_pkg::*;

    localparam int CW    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int NW    = $clog2(MAX_CITIES + 1);
    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = CW + NW;
    localparam int SW    = ((LEN_W > DISTANCE_WIDTH) ? LEN_W : DISTANCE_WIDTH) + 1;
    localparam int N_RST = (CITY_COUNT_RESET > MAX_CITIES) ? MAX_CITIES : CITY_COUNT_RESET;
    localparam int LAST_RST = N_RST * N_RST - 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SCAN,
        S_STEP,
        S_CLOSE_RD,
        S_CLOSE
    } state_t;

    // Distance memory
    logic [DISTANCE_WIDTH-1:0] dist_mem [DEPTH];
    logic [DISTANCE_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]             rd_addr;
    logic                      mem_we;
    logic [DISTANCE_WIDTH-1:0] wr_data;

    // Control and datapath registers
    state_t                    state_reg, state_next;
    logic [NW-1:0]             n_reg, n_next;
    logic [AW-1:0]             last_index_reg, last_index_next;
    logic                      mode_reg, mode_next;
    logic [AW-1:0]             load_pos_reg, load_pos_next;
    logic [MAX_CITIES-1:0]     visited_reg, visited_next;
    logic [AW-1:0]             row_base_reg, row_base_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [NW-1:0]             k_reg, k_next;
    logic [NW-1:0]             step_reg, step_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [CW-1:0]             rd_k_reg, rd_k_next;
    logic                      found_reg, found_next;
    logic [CW-1:0]             best_city_reg, best_city_next;
    logic [DISTANCE_WIDTH-1:0] best_d_reg, best_d_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CITY_OUT_W-1:0]     out_city_reg, out_city_next;
    logic [LEN_W-1:0]          out_len_reg, out_len_next;
    logic                      out_last_reg, out_last_next;

    // Helpers
    logic                      in_xfer;
    logic                      out_free;
    logic                      issue;
    logic [CW-1:0]             k_idx;
    logic                      better;
    logic [NW-1:0]             cfg_n;
    logic [2*NW-1:0]           cfg_sq;
    logic [PW-1:0]             base_prod;
    logic [SW-1:0]             add_sum;
    logic [DISTANCE_WIDTH-1:0] add_d;
    logic [LEN_W-1:0]          len_sat;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_len_reg, out_city_reg});

    // Clamped city count and last load index for a city_count write
    always_comb
    begin
        if (cfg_data < CFG_DATA_W'(2))
            cfg_n = NW'(2);
        else if (cfg_data > CFG_DATA_W'(MAX_CITIES))
            cfg_n = NW'(MAX_CITIES);
        else
            cfg_n = NW'(cfg_data);
        cfg_sq = (2*NW)'(cfg_n) * (2*NW)'(cfg_n);
    end

    // Scan issue and the shared compare unit
    assign k_idx  = k_reg[CW-1:0];
    assign issue  = (state_reg == S_SCAN) && (k_reg < n_reg);
    assign rd_addr = issue ? (row_base_reg + AW'(k_idx)) : row_base_reg;
    assign better = !found_reg ||
                    ((mode_reg == MODE_FARTHEST) ? (rd_data_reg > best_d_reg)
                                                 : (rd_data_reg < best_d_reg));

    // Shared saturating length adder
    assign add_d   = (state_reg == S_CLOSE) ? rd_data_reg : best_d_reg;
    assign add_sum = SW'(len_reg) + SW'(add_d);
    assign len_sat = (add_sum > SW'(LEN_MAX)) ? LEN_MAX : add_sum[LEN_W-1:0];

    // Row base of the chosen city
    assign base_prod = PW'(best_city_reg) * PW'(n_reg);

    // Load path into the memory
    assign mem_we  = in_xfer;
    assign wr_data = DISTANCE_WIDTH'(s_axis_tdata[DIST_IN_W-1:0]);

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        last_index_next = last_index_reg;
        mode_next       = mode_reg;
        load_pos_next   = load_pos_reg;
        visited_next    = visited_reg;
        row_base_next   = row_base_reg;
        len_next        = len_reg;
        k_next          = k_reg;
        step_next       = step_reg;
        rd_valid_next   = 1'b0;
        rd_k_next       = k_idx;
        found_next      = found_reg;
        best_city_next  = best_city_reg;
        best_d_next     = best_d_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_city_next   = out_city_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;

        // Matrix load
        if (in_xfer)
        begin
            if (load_pos_reg == last_index_reg)
            begin
                load_pos_next = '0;
                state_next    = S_START;
            end
            else
            begin
                load_pos_next = load_pos_reg + AW'(1);
            end
        end

        // Configuration writes must arrive only while the block is idle; the block itself does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CITY_COUNT:
                begin
                    n_next          = cfg_n;
                    last_index_next = AW'(cfg_sq - (2*NW)'(1));
                    load_pos_next   = '0;
                end
                CFG_TOUR_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_LOAD:
            begin
            end

            // Emit city 0 and set up the first step
            S_START:
            begin
                if (out_free)
                begin
                    visited_next   = MAX_CITIES'(1);
                    row_base_next  = '0;
                    len_next       = '0;
                    step_next      = NW'(1);
                    k_next         = '0;
                    found_next     = 1'b0;
                    out_valid_next = 1'b1;
                    out_city_next  = '0;
                    out_len_next   = '0;
                    out_last_next  = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            // One candidate read per cycle, compared once its registered read data returns
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_valid_next = !visited_reg[k_idx];
                    k_next        = k_reg + NW'(1);
                end
                if (rd_valid_reg && better)
                begin
                    found_next     = 1'b1;
                    best_city_next = rd_k_reg;
                    best_d_next    = rd_data_reg;
                end
                if (!issue && !rd_valid_reg)
                    state_next = S_STEP;
            end

            // Move to the chosen city and report it
            S_STEP:
            begin
                if (out_free)
                begin
                    visited_next[best_city_reg] = 1'b1;
                    len_next       = len_sat;
                    row_base_next  = base_prod[AW-1:0];
                    out_valid_next = 1'b1;
                    out_city_next  = CITY_OUT_W'(best_city_reg);
                    out_len_next   = len_sat;
                    out_last_next  = 1'b0;
                    k_next         = '0;
                    found_next     = 1'b0;
                    step_next      = step_reg + NW'(1);
                    if (step_reg == n_reg - NW'(1))
                        state_next = S_CLOSE_RD;
                    else
                        state_next = S_SCAN;
                end
            end

            // Fetch the edge back to city 0
            S_CLOSE_RD:
            begin
                state_next = S_CLOSE;
            end

            S_CLOSE:
            begin
                if (out_free)
                begin
                    len_next       = len_sat;
                    out_valid_next = 1'b1;
                    out_city_next  = '0;
                    out_len_next   = len_sat;
                    out_last_next  = 1'b1;
                    state_next     = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            n_reg          <= NW'(N_RST);
            last_index_reg <= AW'(LAST_RST);
            mode_reg       <= MODE_NEAREST;
            load_pos_reg   <= '0;
            visited_reg    <= '0;
            row_base_reg   <= '0;
            len_reg        <= '0;
            k_reg          <= '0;
            step_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            rd_k_reg       <= '0;
            found_reg      <= 1'b0;
            best_city_reg  <= '0;
            best_d_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_city_reg   <= '0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            last_index_reg <= last_index_next;
            mode_reg       <= mode_next;
            load_pos_reg   <= load_pos_next;
            visited_reg    <= visited_next;
            row_base_reg   <= row_base_next;
            len_reg        <= len_next;
            k_reg          <= k_next;
            step_reg       <= step_next;
            rd_valid_reg   <= rd_valid_next;
            rd_k_reg       <= rd_k_next;
            found_reg      <= found_next;
            best_city_reg  <= best_city_next;
            best_d_reg     <= best_d_next;
            out_valid_reg  <= out_valid_next;
            out_city_reg   <= out_city_next;
            out_len_reg    <= out_len_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Distance memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            dist_mem[load_pos_reg] <= wr_data;
        rd_data_reg <= dist_mem[rd_addr];
    end

    // City 0 stays visited for the whole scan.
    a_start_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> visited_reg[0])
        else $error("city 0 not marked visited during a scan");

    // The visited count tracks the step count.
    a_visited_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ($countones(visited_reg) == int'(step_reg)))
        else $error("visited marks out of step with the tour position");

    // A chosen city was never visited before.
    a_best_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (found_reg && !visited_reg[best_city_reg]))
        else $error("step picked a visited city or none");

    // The load position never passes the end of the matrix.
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_pos_reg <= last_index_reg)
        else $error("load position beyond the matrix");

    // Closing the tour presents the final result and reopens the input.
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLOSE && out_free) |=>
        (state_reg == S_LOAD && m_axis_tvalid && m_axis_tlast))
        else $error("tour close did not present the final result");

endmodule

`default_nettype wire
